>>> hdl/oass_pkg.sv
// types, codes and defaults shared by the ordered atomic store sequencer
package oass_pkg;

  localparam int DEF_MAX_RANKS = 16;
  localparam int DEF_MAX_VARS  = 64;
  localparam int RANK_LIMIT    = 16;

  localparam logic [1:0] OP_WRITE    = 2'd0;
  localparam logic [1:0] OP_CAS      = 2'd1;
  localparam logic [1:0] OP_SHUTDOWN = 2'd2;
  localparam logic [1:0] OP_INVALID  = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOT_SUB = 2'd1;
  localparam logic [1:0] STAT_BAD     = 2'd2;
  localparam logic [1:0] STAT_STOPPED = 2'd3;

  localparam logic KIND_COMPLETION = 1'b0;
  localparam logic KIND_FORWARD    = 1'b1;

  localparam logic CFG_RANK_COUNT    = 1'b0;
  localparam logic CFG_VARS_PER_RANK = 1'b1;

  localparam logic [4:0] RANK_COUNT_RST    = 5'd4;
  localparam logic [6:0] VARS_PER_RANK_RST = 7'd64;

  typedef struct packed {
    logic [1:0]         operation;
    logic [3:0]         requester;
    logic [3:0]         home_rank;
    logic [5:0]         local_index;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic [15:0]        request_tag;
  } oass_in_t;

  typedef struct packed {
    logic               kind;
    logic [3:0]         destination;
    logic [31:0]        sequence_res;
    logic [1:0]         op_kind;
    logic [3:0]         out_home_rank;
    logic [5:0]         out_local_index;
    logic signed [31:0] new_value;
    logic [15:0]        echo_tag;
    logic [1:0]         status;
    logic               swap_success;
    logic               changed;
    logic               last;
  } oass_out_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_APPLY,
    S_FWD
  } oass_state_t;

  typedef struct packed {
    logic load;
    logic clr_wr;
    logic decide;
    logic apply;
    logic fwd;
  } oass_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic go_apply;
    logic more;
  } oass_sts_t;

endpackage

>>> hdl/oass_ctrl.sv
// control state machine of the ordered atomic store sequencer
module oass_ctrl import oass_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  oass_sts_t sts,
  output oass_cmd_t cmd
);

  oass_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.decide = 1'b1;
        priority if (sts.go_apply) begin
          state_nxt = S_APPLY;
        end else if (sts.more) begin
          state_nxt = S_FWD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = sts.more ? S_FWD : S_IDLE;
      end
      S_FWD: begin
        cmd.fwd   = 1'b1;
        state_nxt = sts.more ? S_FWD : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/oass_dp.sv
// datapath: request register, value store, sequence counter and result register
module oass_dp import oass_pkg::*; #(
  parameter int MAX_RANKS = DEF_MAX_RANKS,
  parameter int MAX_VARS  = DEF_MAX_VARS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  oass_in_t   in_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data,
  input  oass_cmd_t  cmd,
  output oass_sts_t  sts,
  output logic       out_strobe,
  output oass_out_t  out_data
);

  localparam int DEPTH = MAX_RANKS * MAX_VARS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int GW    = 12;
  localparam int SW    = (AW > GW) ? AW : GW;
  localparam int RCAP  = (MAX_RANKS < RANK_LIMIT) ? MAX_RANKS : RANK_LIMIT;
  localparam int VCAP  = (MAX_VARS < 127) ? MAX_VARS : 127;

  logic [31:0] store [DEPTH];

  logic [4:0]  rank_count_r;
  logic [6:0]  vars_per_rank_r;
  logic        running_r, running_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [AW-1:0] clr_addr_r;
  oass_in_t    req_r;
  logic [31:0] rd_data_r;
  logic [15:0] fwd_r, fwd_nxt;
  logic        out_valid_r;
  oass_out_t   out_r, out_nxt;

  logic [4:0]  rc;
  logic [6:0]  vc;
  logic [4:0]  h1, h2;
  logic [3:0]  s0, s1, s2;
  logic        err_addr, is_sub, go_apply;
  logic [15:0] sub_mask, shut_mask, fwd_rest;
  logic [3:0]  pick;
  logic [SW-1:0] gid;
  logic [AW-1:0] addr;
  logic [31:0] cur, new_val;
  logic        swp, chg, emit;
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0] mem_wd;

  // effective register values
  always_comb begin
    if (rank_count_r == 5'd0) begin
      rc = 5'd1;
    end else if (int'(rank_count_r) > RCAP) begin
      rc = 5'(RCAP);
    end else begin
      rc = rank_count_r;
    end
    if (vars_per_rank_r == 7'd0) begin
      vc = 7'd1;
    end else if (int'(vars_per_rank_r) > VCAP) begin
      vc = 7'(VCAP);
    end else begin
      vc = vars_per_rank_r;
    end
  end

  // subscribers and checks
  always_comb begin
    h1 = {1'b0, req_r.home_rank} + 5'd1;
    h2 = {1'b0, req_r.home_rank} + 5'd2;
    if (h1 >= rc) h1 = h1 - rc;
    if (h2 >= rc) h2 = h2 - rc;
    s0 = req_r.home_rank;
    s1 = (rc >= 5'd2) ? h1[3:0] : req_r.home_rank;
    s2 = (rc >= 5'd3) ? h2[3:0] : req_r.home_rank;
    sub_mask = (16'd1 << s0) | (16'd1 << s1) | (16'd1 << s2);
    is_sub = (req_r.requester == s0) || (req_r.requester == s1) ||
             (req_r.requester == s2);
    err_addr = (req_r.operation == OP_INVALID) ||
               ({1'b0, req_r.home_rank} >= rc) ||
               ({1'b0, req_r.local_index} >= vc);
    go_apply = running_r && (req_r.operation != OP_SHUTDOWN) && !err_addr && is_sub;
    for (int i = 0; i < 16; i++) begin
      shut_mask[i] = (i != 0) && (i < int'(rc));
    end
    gid  = SW'(req_r.home_rank) * SW'(vc) + SW'(req_r.local_index);
    addr = gid[AW-1:0];
  end

  // lowest pending forward
  always_comb begin
    pick = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (fwd_r[i]) pick = 4'(i);
    end
    fwd_rest = fwd_r & (fwd_r - 16'd1);
  end

  // update of the addressed variable
  always_comb begin
    cur     = rd_data_r;
    swp     = 1'b0;
    chg     = 1'b0;
    new_val = cur;
    if (req_r.operation == OP_WRITE) begin
      new_val = req_r.first_value;
      chg     = (cur != req_r.first_value);
    end else begin
      swp = (cur == req_r.first_value);
      if (swp) begin
        new_val = req_r.second_value;
        chg     = (cur != req_r.second_value);
      end
    end
  end

  always_comb begin
    out_nxt     = out_r;
    fwd_nxt     = fwd_r;
    running_nxt = running_r;
    seq_nxt     = seq_r;
    emit        = 1'b0;
    if (cmd.decide) begin
      fwd_nxt = '0;
      out_nxt.kind            = KIND_COMPLETION;
      out_nxt.destination     = req_r.requester;
      out_nxt.sequence_res    = '0;
      out_nxt.op_kind         = req_r.operation;
      out_nxt.out_home_rank   = req_r.home_rank;
      out_nxt.out_local_index = req_r.local_index;
      out_nxt.new_value       = '0;
      out_nxt.echo_tag        = req_r.request_tag;
      out_nxt.status          = STAT_OK;
      out_nxt.swap_success    = 1'b0;
      out_nxt.changed         = 1'b0;
      out_nxt.last            = 1'b1;
      emit = !go_apply;
      priority if (!running_r) begin
        out_nxt.status = STAT_STOPPED;
      end else if (req_r.operation == OP_SHUTDOWN) begin
        running_nxt             = 1'b0;
        seq_nxt                 = seq_r + 32'd1;
        fwd_nxt                 = shut_mask;
        out_nxt.sequence_res    = seq_r;
        out_nxt.out_home_rank   = '0;
        out_nxt.out_local_index = '0;
        out_nxt.last            = (shut_mask == 16'd0);
      end else if (err_addr) begin
        running_nxt    = 1'b0;
        out_nxt.status = STAT_BAD;
      end else if (!is_sub) begin
        running_nxt    = 1'b0;
        out_nxt.status = STAT_NOT_SUB;
      end else begin
        fwd_nxt = sub_mask & ~16'd1;
      end
    end else if (cmd.apply) begin
      emit                 = 1'b1;
      seq_nxt              = seq_r + 32'd1;
      out_nxt.sequence_res = seq_r;
      out_nxt.new_value    = new_val;
      out_nxt.swap_success = swp;
      out_nxt.changed      = chg;
      out_nxt.last         = (fwd_r == 16'd0);
    end else if (cmd.fwd) begin
      emit                = 1'b1;
      fwd_nxt             = fwd_rest;
      out_nxt.kind        = KIND_FORWARD;
      out_nxt.destination = pick;
      out_nxt.last        = (fwd_rest == 16'd0);
    end
  end

  assign sts.clr_done = (clr_addr_r == AW'(DEPTH - 1));
  assign sts.go_apply = go_apply;
  assign sts.more     = (fwd_nxt != 16'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_count_r    <= RANK_COUNT_RST;
      vars_per_rank_r <= VARS_PER_RANK_RST;
      running_r       <= 1'b1;
      seq_r           <= '0;
      clr_addr_r      <= '0;
      fwd_r           <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RANK_COUNT:    rank_count_r    <= cfg_data[4:0];
          CFG_VARS_PER_RANK: vars_per_rank_r <= cfg_data;
          default: ;
        endcase
      end
      running_r   <= running_nxt;
      seq_r       <= seq_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= emit;
      if (cmd.clr_wr && !sts.clr_done) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (emit || cmd.decide) begin
      out_r <= out_nxt;
    end
  end

  // value store, one read and one write port
  always_comb begin
    mem_we = cmd.clr_wr || cmd.apply;
    mem_wa = cmd.clr_wr ? clr_addr_r : addr;
    mem_wd = cmd.clr_wr ? 32'd0 : new_val;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_wa] <= mem_wd;
    end
    if (cmd.decide) begin
      rd_data_r <= store[addr];
    end
  end

  assign out_strobe = out_valid_r;
  assign out_data   = out_r;

endmodule

>>> hdl/ordered_atomic_store_sequencer.sv
// top level of the ordered atomic store sequencer
// After reset the block clears its value store, one entry a cycle, all
// MAX_RANKS*MAX_VARS entries (1024 at the defaults) with busy high; register
// writes are taken meanwhile. A request is taken when start is high and busy
// is low. A write or compare-and-swap is registered, then the value store is
// read in the check state; in the apply state the variable is written and the
// completion registered, and each forwarded update follows in its own forward
// state. Errors and requests while stopped give only a completion, registered
// in the check state; a shutdown gives its completion and then one forward per
// configured rank above rank 0. Every result is shown for exactly one cycle
// with out_strobe high: the receiver cannot hold results off, so it must take
// each one as it comes.
module ordered_atomic_store_sequencer import oass_pkg::*; #(
  parameter int MAX_RANKS = DEF_MAX_RANKS,
  parameter int MAX_VARS  = DEF_MAX_VARS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  oass_in_t   in_data,
  output logic       out_strobe,
  output oass_out_t  out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);

  oass_cmd_t cmd;
  oass_sts_t sts;

  oass_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  oass_dp #(
    .MAX_RANKS (MAX_RANKS),
    .MAX_VARS  (MAX_VARS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
